@@ design/srm_pkg.sv @@
`timescale 1ns / 1ps

package srm_pkg;

	// Bus timer width; delays saturate at the largest count it holds.
	localparam int TIMER_WIDTH = 24;

	localparam int ADDR_W  = 8;
	localparam int DATA_W  = 8;
	localparam int TICKS_W = 16;
	localparam int POLL_W  = 10;
	localparam int CFG_IDX_W = 2;

	// Widest delay multiplier is the 100-unit gap, which needs seven bits.
	localparam int MULT_W = 7;
	localparam int PROD_W = TICKS_W + MULT_W;
	localparam int SAT_W  = (TIMER_WIDTH > PROD_W) ? TIMER_WIDTH : PROD_W;

	// Delays in microsecond units.
	localparam int START_UNITS = 4;
	localparam int BIT_UNITS   = 2;
	localparam int ACK_UNITS   = 1;
	localparam int GAP_UNITS   = 100;
	localparam int NACK_UNITS  = 4;
	localparam int STOP_UNITS  = 4;

	localparam logic [ADDR_W-1:0]  DEV_ADDR_RST  = 8'd66;
	localparam logic [TICKS_W-1:0] TICKS_RST     = 16'd50;
	localparam logic [POLL_W-1:0]  POLL_LIM_RST  = 10'd250;
	localparam logic [ADDR_W-1:0]  READ_BIT_MASK = 8'h01;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIM = 2'd2;

	// Input kind codes as they arrive on the port.
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	// Queue between the front and back parts.
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] reg_addr;
		logic [DATA_W-1:0] write_data;
		logic              sda;
	} item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  dev_addr;
		logic [TICKS_W-1:0] ticks;
		logic [POLL_W-1:0]  poll_limit;
	} cfg_t;

	typedef struct packed {
		logic              scl;
		logic              sda_out;
		logic              sda_drive;
		logic              busy;
		logic              done;
		logic              failed;
		logic [DATA_W-1:0] read_data;
	} res_t;

	// Bus sequencer phases.
	typedef enum logic [18:0] {
		PH_IDLE      = 19'h00001,
		PH_START_HI  = 19'h00002,
		PH_START_LO  = 19'h00004,
		PH_WB_SETUP  = 19'h00008,
		PH_WB_HIGH   = 19'h00010,
		PH_WB_LOW    = 19'h00020,
		PH_ACK_REL   = 19'h00040,
		PH_ACK_RISE  = 19'h00080,
		PH_ACK_POLL  = 19'h00100,
		PH_ACK_END   = 19'h00200,
		PH_GAP       = 19'h00400,
		PH_RB_LOW    = 19'h00800,
		PH_RB_HIGH   = 19'h01000,
		PH_NACK_SET  = 19'h02000,
		PH_NACK_HIGH = 19'h04000,
		PH_NACK_LOW  = 19'h08000,
		PH_STOP_LO   = 19'h10000,
		PH_STOP_HI   = 19'h20000,
		PH_REGAP     = 19'h40000
	} phase_t;

	// Delay of n units in ticks, clipped to the timer range.
	function automatic logic [TIMER_WIDTH-1:0] units(input logic [TICKS_W-1:0] ticks,
			input logic [MULT_W-1:0] n);
		logic [PROD_W-1:0] prod;
		logic [SAT_W-1:0]  wide;
		logic [SAT_W-1:0]  lim;
		prod = PROD_W'(ticks) * PROD_W'(n);
		wide = SAT_W'(prod);
		lim  = SAT_W'({TIMER_WIDTH{1'b1}});
		if (wide > lim) begin
			return lim[TIMER_WIDTH-1:0];
		end
		return wide[TIMER_WIDTH-1:0];
	endfunction

endpackage

@@ design/srm_front.sv @@
`timescale 1ns / 1ps

module srm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 kind,
	input  logic [srm_pkg::ADDR_W-1:0] reg_addr,
	input  logic [srm_pkg::DATA_W-1:0] write_data,
	input  logic                       sda_in,
	output logic                       push_valid,
	output srm_pkg::item_t             push_item,
	input  logic                       push_ready
);
	import srm_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	cmd_t  cmd;

	// Unused kind code three behaves as a plain tick.
	always_comb begin
		case (kind)
			KIND_WRITE: cmd = CMD_WRITE;
			KIND_READ:  cmd = CMD_READ;
			default:    cmd = CMD_TICK;
		endcase
	end

	assign in_stall   = valid_s1 && !push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{cmd: cmd, reg_addr: reg_addr, write_data: write_data, sda: sda_in};
		end
	end

endmodule

@@ design/srm_queue.sv @@
`timescale 1ns / 1ps

module srm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  srm_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output srm_pkg::item_t pop_item,
	input  logic           pop
);
	import srm_pkg::*;

	item_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != QCW'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/srm_back.sv @@
`timescale 1ns / 1ps

module srm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  srm_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  srm_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	output srm_pkg::res_t  out_res,
	input  logic           out_stall
);
	import srm_pkg::*;

	typedef struct packed {
		phase_t                 phase;
		logic                   scl;
		logic                   sda;
		logic                   drv;
		logic [TIMER_WIDTH-1:0] delay;
	} line_t;

	function automatic line_t go_to(input phase_t ph, input logic scl, input logic sda,
			input logic drv, input logic [TIMER_WIDTH-1:0] d);
		line_t l;
		l.phase = ph;
		l.scl   = scl;
		l.sda   = sda;
		l.drv   = drv;
		l.delay = d;
		return l;
	endfunction

	line_t               line_q, line_n;
	logic [2:0]          bit_q, bit_n;
	logic [DATA_W-1:0]   shift_q, shift_n;
	logic [POLL_W-1:0]   poll_q, poll_n;
	logic                is_read_q, is_read_n;
	logic [ADDR_W-1:0]   held_reg_q, held_reg_n;
	logic [DATA_W-1:0]   held_data_q, held_data_n;
	logic                err_q, err_n;
	logic [DATA_W-1:0]   last_read_q, last_read_n;
	logic [1:0]          stage_q, stage_n;
	logic                done_n, fail_n;
	logic                fire;
	logic [DATA_W-1:0]   tx_byte;

	logic [TIMER_WIDTH-1:0] u1, u2, u4, u100;

	assign u1   = units(cfg.ticks, MULT_W'(ACK_UNITS));
	assign u2   = units(cfg.ticks, MULT_W'(BIT_UNITS));
	assign u4   = units(cfg.ticks, MULT_W'(START_UNITS));
	assign u100 = units(cfg.ticks, MULT_W'(GAP_UNITS));

	assign fire  = q_valid && (!out_valid || !out_stall);
	assign q_pop = fire;

	// Byte sent after a start: the address, then the register, then data or read address.
	always_comb begin
		case (stage_q)
			2'd0:    tx_byte = cfg.dev_addr;
			2'd1:    tx_byte = held_reg_q;
			default: tx_byte = is_read_q ? (cfg.dev_addr | READ_BIT_MASK) : held_data_q;
		endcase
	end

	always_comb begin
		line_n      = line_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		poll_n      = poll_q;
		is_read_n   = is_read_q;
		held_reg_n  = held_reg_q;
		held_data_n = held_data_q;
		err_n       = err_q;
		last_read_n = last_read_q;
		stage_n     = stage_q;
		done_n      = 1'b0;
		fail_n      = 1'b0;

		if (line_q.phase == PH_IDLE) begin
			if (q_item.cmd == CMD_WRITE || q_item.cmd == CMD_READ) begin
				held_reg_n  = q_item.reg_addr;
				held_data_n = q_item.write_data;
				is_read_n   = (q_item.cmd == CMD_READ);
				err_n       = 1'b0;
				stage_n     = 2'd0;
				line_n      = go_to(PH_START_HI, 1'b1, 1'b1, 1'b1, u4);
			end
		end else if (line_q.phase == PH_ACK_POLL) begin
			if (!q_item.sda) begin
				line_n = go_to(PH_ACK_END, 1'b0, 1'b1, 1'b0, u1);
			end else if (poll_q >= cfg.poll_limit) begin
				err_n  = 1'b1;
				line_n = go_to(PH_STOP_LO, 1'b0, 1'b0, 1'b1, u4);
			end else begin
				poll_n = poll_q + 1'b1;
			end
		end else if (line_q.delay > TIMER_WIDTH'(1)) begin
			line_n.delay = line_q.delay - 1'b1;
		end else begin
			line_n.delay = '0;
			case (line_q.phase)
				PH_START_HI: line_n = go_to(PH_START_LO, 1'b1, 1'b0, 1'b1, u4);
				PH_START_LO: begin
					shift_n = tx_byte;
					bit_n   = '0;
					line_n  = go_to(PH_WB_SETUP, 1'b0, tx_byte[DATA_W-1], 1'b1, u2);
				end
				PH_WB_SETUP: line_n = go_to(PH_WB_HIGH, 1'b1, line_q.sda, 1'b1, u2);
				PH_WB_HIGH:  line_n = go_to(PH_WB_LOW, 1'b0, line_q.sda, 1'b1, u2);
				PH_WB_LOW: begin
					if (bit_q != 3'd7) begin
						bit_n   = bit_q + 1'b1;
						shift_n = {shift_q[DATA_W-2:0], 1'b0};
						line_n  = go_to(PH_WB_SETUP, 1'b0, shift_q[DATA_W-2], 1'b1, u2);
					end else begin
						line_n = go_to(PH_ACK_REL, 1'b0, 1'b1, 1'b0, u1);
					end
				end
				PH_ACK_REL: begin
					poll_n = '0;
					line_n = go_to(PH_ACK_RISE, 1'b1, 1'b1, 1'b0, u1);
				end
				PH_ACK_RISE: line_n = go_to(PH_ACK_POLL, 1'b1, 1'b1, 1'b0, '0);
				PH_ACK_END: begin
					if (!is_read_q && stage_q == 2'd2) begin
						line_n = go_to(PH_STOP_LO, 1'b0, 1'b0, 1'b1, u4);
					end else begin
						line_n = go_to(PH_GAP, 1'b0, 1'b1, 1'b0, u100);
					end
				end
				PH_GAP: begin
					if (stage_q == 2'd0) begin
						stage_n = 2'd1;
						shift_n = held_reg_q;
						bit_n   = '0;
						line_n  = go_to(PH_WB_SETUP, 1'b0, held_reg_q[ADDR_W-1], 1'b1, u2);
					end else if (!is_read_q && stage_q == 2'd1) begin
						stage_n = 2'd2;
						shift_n = held_data_q;
						bit_n   = '0;
						line_n  = go_to(PH_WB_SETUP, 1'b0, held_data_q[DATA_W-1], 1'b1, u2);
					end else if (!is_read_q || stage_q == 2'd1) begin
						line_n = go_to(PH_STOP_LO, 1'b0, 1'b0, 1'b1, u4);
					end else begin
						bit_n   = '0;
						shift_n = '0;
						line_n  = go_to(PH_RB_LOW, 1'b0, 1'b1, 1'b0, u1);
					end
				end
				PH_RB_LOW: line_n = go_to(PH_RB_HIGH, 1'b1, 1'b1, 1'b0, TIMER_WIDTH'(1));
				PH_RB_HIGH: begin
					shift_n = {shift_q[DATA_W-2:0], q_item.sda};
					if (bit_q != 3'd7) begin
						bit_n  = bit_q + 1'b1;
						line_n = go_to(PH_RB_LOW, 1'b0, 1'b1, 1'b0, u1);
					end else begin
						last_read_n = {shift_q[DATA_W-2:0], q_item.sda};
						line_n      = go_to(PH_NACK_SET, 1'b0, 1'b1, 1'b1, u1);
					end
				end
				PH_NACK_SET:  line_n = go_to(PH_NACK_HIGH, 1'b1, 1'b1, 1'b1, u4);
				PH_NACK_HIGH: line_n = go_to(PH_NACK_LOW, 1'b0, 1'b1, 1'b1, u4);
				PH_NACK_LOW:  line_n = go_to(PH_STOP_LO, 1'b0, 1'b0, 1'b1, u4);
				PH_STOP_LO:   line_n = go_to(PH_STOP_HI, 1'b1, 1'b1, 1'b1, u4);
				PH_STOP_HI: begin
					if (is_read_q && stage_q == 2'd1 && !err_q) begin
						line_n = go_to(PH_REGAP, 1'b1, 1'b1, 1'b1, u100);
					end else begin
						line_n = go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
						done_n = 1'b1;
						fail_n = err_q;
					end
				end
				PH_REGAP: begin
					stage_n = 2'd2;
					line_n  = go_to(PH_START_HI, 1'b1, 1'b1, 1'b1, u4);
				end
				default: line_n = go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q      <= go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
			bit_q       <= '0;
			shift_q     <= '0;
			poll_q      <= '0;
			is_read_q   <= 1'b0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			err_q       <= 1'b0;
			last_read_q <= '0;
			stage_q     <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (fire) begin
				line_q      <= line_n;
				bit_q       <= bit_n;
				shift_q     <= shift_n;
				poll_q      <= poll_n;
				is_read_q   <= is_read_n;
				held_reg_q  <= held_reg_n;
				held_data_q <= held_data_n;
				err_q       <= err_n;
				last_read_q <= last_read_n;
				stage_q     <= stage_n;
				out_valid   <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res.scl       <= line_n.scl;
			out_res.sda_out   <= line_n.drv ? line_n.sda : 1'b1;
			out_res.sda_drive <= line_n.drv;
			out_res.busy      <= (line_n.phase != PH_IDLE);
			out_res.done      <= done_n;
			out_res.failed    <= fail_n;
			out_res.read_data <= last_read_n;
		end
	end

endmodule

@@ design/sccb_register_master.sv @@
`timescale 1ns / 1ps

// SCCB register master. Each transfer on the input channel is one tick of bus
// time: it carries a command kind (tick only, register write or register read),
// the register address, the write byte and the sampled SDA level. Every input
// transfer produces exactly one output transfer with the SCL level, the SDA
// drive level and enable, busy, a one-tick done pulse, failed (valid with done)
// and the byte of the last completed read. Commands that arrive while busy are
// ignored. Configuration (device address, ticks per microsecond unit, ack poll
// limit) is written over a separate valid/ready port that is always ready, and
// should only be written while the bus is idle.
// Each input transfer passes the front, queue and output registers. The block
// takes one tick per cycle: the bus sequencer retires one queued tick each
// cycle the output register is free or being emptied.
// When the receiver stalls, the result holds in the output register, the queue
// fills behind it and the input stall rises once the front register cannot
// move on. Reset puts the bus idle (SCL and SDA high, SDA driven), clears all
// transaction state and loads the default configuration.
module sccb_register_master (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [srm_pkg::ADDR_W-1:0]    reg_addr,
	input  logic [srm_pkg::DATA_W-1:0]    write_data,
	input  logic                          sda_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          scl,
	output logic                          sda_out,
	output logic                          sda_drive,
	output logic                          busy_res,
	output logic                          done_res,
	output logic                          failed,
	output logic [srm_pkg::DATA_W-1:0]    read_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [srm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srm_pkg::TICKS_W-1:0]   cfg_data
);
	import srm_pkg::*;

	cfg_t  cfg_q;
	logic  push_valid;
	item_t push_item;
	logic  push_ready;
	logic  pop_valid;
	item_t pop_item;
	logic  pop;
	res_t  res;

	// The configuration registers accept a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr   <= DEV_ADDR_RST;
			cfg_q.ticks      <= TICKS_RST;
			cfg_q.poll_limit <= POLL_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEV_ADDR: cfg_q.dev_addr   <= cfg_data[ADDR_W-1:0];
				CFG_TICKS:    cfg_q.ticks      <= cfg_data;
				CFG_POLL_LIM: cfg_q.poll_limit <= cfg_data[POLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front: registers and classifies each incoming tick.
	srm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.sda_in     (sda_in),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// Short queue so the front keeps taking ticks while the output is stalled.
	srm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	// Back: the bus sequencer, advanced one tick per queued item.
	srm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (pop_valid),
		.q_item    (pop_item),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_res   (res),
		.out_stall (out_stall)
	);

	assign scl       = res.scl;
	assign sda_out   = res.sda_out;
	assign sda_drive = res.sda_drive;
	assign busy_res  = res.busy;
	assign done_res  = res.done;
	assign failed    = res.failed;
	assign read_data = res.read_data;

	// A finished transaction leaves the bus idle in the same tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && scl && sda_drive && sda_out)
		else $error("done reported while the bus is not idle");

	// Failure is only reported together with done.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> done_res)
		else $error("failed raised without done");

	// A released SDA line reads as high, and SDA is only released inside a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sda_drive |-> sda_out && busy_res)
		else $error("released SDA reported low or outside a transaction");

	// The read byte only changes within a busy read transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) && (read_data != $past(read_data)) |-> busy_res)
		else $error("read byte changed while idle");

endmodule

@@ dv/srm_bus_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels and the configuration port of the SCCB master, keeps
// its own copy of the bus sequencer and compares every output transfer with
// the line levels it predicts for the matching input transfer.
module srm_bus_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    kind,
	input  logic [srm_pkg::ADDR_W-1:0]    reg_addr,
	input  logic [srm_pkg::DATA_W-1:0]    write_data,
	input  logic                          sda_in,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          scl,
	input  logic                          sda_out,
	input  logic                          sda_drive,
	input  logic                          busy_res,
	input  logic                          done_res,
	input  logic                          failed,
	input  logic [srm_pkg::DATA_W-1:0]    read_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [srm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [srm_pkg::TICKS_W-1:0]   cfg_data,
	output int                            err_count,
	output int                            pending,
	output logic                          bus_idle,
	output int                            ticks_checked,
	output int                            txn_done,
	output int                            txn_failed
);
	import srm_pkg::*;

	// Configuration copy.
	logic [ADDR_W-1:0]  dev_addr_q;
	logic [TICKS_W-1:0] tpu_q;
	logic [POLL_W-1:0]  poll_lim_q;

	// Sequencer copy.
	phase_t                 ph;
	logic [3:0]             bit_cnt;
	logic [7:0]             shreg;
	logic [TIMER_WIDTH-1:0] dly;
	logic [POLL_W-1:0]      poll_cnt;
	logic                   rd_cmd;
	logic [ADDR_W-1:0]      hold_reg;
	logic [DATA_W-1:0]      hold_data;
	logic [DATA_W-1:0]      last_rd;
	logic                   err;
	logic [1:0]             byte_idx;
	logic                   scl_l, sda_l, drv_l;
	logic                   done_now, fail_now;

	res_t line_queue[$];
	int   errs, seen, n_done, n_fail;

	function automatic logic [TIMER_WIDTH-1:0] unit_ticks(input int unsigned n);
		logic [63:0] t;
		logic [63:0] lim;
		lim = (64'd1 << TIMER_WIDTH) - 64'd1;
		t = 64'(n) * 64'(tpu_q);
		if (t > lim) begin
			t = lim;
		end
		return TIMER_WIDTH'(t);
	endfunction

	function automatic void go_to(input phase_t p, input logic c, input logic d, input logic e,
			input logic [TIMER_WIDTH-1:0] t);
		ph = p;
		scl_l = c;
		sda_l = d;
		drv_l = e;
		dly = t;
	endfunction

	function automatic void load_byte();
		logic [7:0] b;
		if (byte_idx == 2'd0) begin
			b = dev_addr_q;
		end else if (byte_idx == 2'd1) begin
			b = hold_reg;
		end else begin
			b = rd_cmd ? (dev_addr_q | READ_BIT_MASK) : hold_data;
		end
		shreg = b;
		bit_cnt = 4'd0;
		go_to(PH_WB_SETUP, 1'b0, b[7], 1'b1, unit_ticks(BIT_UNITS));
	endfunction

	function automatic void stop_seq();
		go_to(PH_STOP_LO, 1'b0, 1'b0, 1'b1, unit_ticks(STOP_UNITS));
	endfunction

	function automatic void seq_reset();
		dev_addr_q = DEV_ADDR_RST;
		tpu_q = TICKS_RST;
		poll_lim_q = POLL_LIM_RST;
		bit_cnt = '0;
		shreg = '0;
		poll_cnt = '0;
		rd_cmd = 1'b0;
		hold_reg = '0;
		hold_data = '0;
		err = 1'b0;
		last_rd = '0;
		byte_idx = '0;
		done_now = 1'b0;
		fail_now = 1'b0;
		go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
	endfunction

	// Moves on once the current delay has run out.
	function automatic void phase_done(input logic sda);
		case (ph)
			PH_START_HI: go_to(PH_START_LO, 1'b1, 1'b0, 1'b1, unit_ticks(START_UNITS));
			PH_START_LO: load_byte();
			PH_WB_SETUP: go_to(PH_WB_HIGH, 1'b1, sda_l, 1'b1, unit_ticks(BIT_UNITS));
			PH_WB_HIGH:  go_to(PH_WB_LOW, 1'b0, sda_l, 1'b1, unit_ticks(BIT_UNITS));
			PH_WB_LOW: begin
				if (bit_cnt < 4'd7) begin
					bit_cnt++;
					shreg = shreg << 1;
					go_to(PH_WB_SETUP, 1'b0, shreg[7], 1'b1, unit_ticks(BIT_UNITS));
				end else begin
					go_to(PH_ACK_REL, 1'b0, 1'b1, 1'b0, unit_ticks(ACK_UNITS));
				end
			end
			PH_ACK_REL: begin
				poll_cnt = '0;
				go_to(PH_ACK_RISE, 1'b1, 1'b1, 1'b0, unit_ticks(ACK_UNITS));
			end
			PH_ACK_RISE: go_to(PH_ACK_POLL, 1'b1, 1'b1, 1'b0, '0);
			PH_ACK_END: begin
				if (!rd_cmd && byte_idx >= 2'd2) begin
					stop_seq();
				end else begin
					go_to(PH_GAP, 1'b0, 1'b1, 1'b0, unit_ticks(GAP_UNITS));
				end
			end
			PH_GAP: begin
				if (byte_idx == 2'd0) begin
					byte_idx = 2'd1;
					load_byte();
				end else if (!rd_cmd) begin
					if (byte_idx == 2'd1) begin
						byte_idx = 2'd2;
						load_byte();
					end else begin
						stop_seq();
					end
				end else if (byte_idx == 2'd1) begin
					stop_seq();
				end else begin
					bit_cnt = '0;
					shreg = '0;
					go_to(PH_RB_LOW, 1'b0, 1'b1, 1'b0, unit_ticks(ACK_UNITS));
				end
			end
			// The high half of a read bit is always a single tick.
			PH_RB_LOW: go_to(PH_RB_HIGH, 1'b1, 1'b1, 1'b0, TIMER_WIDTH'(1));
			PH_RB_HIGH: begin
				shreg = {shreg[6:0], sda};
				if (bit_cnt < 4'd7) begin
					bit_cnt++;
					go_to(PH_RB_LOW, 1'b0, 1'b1, 1'b0, unit_ticks(ACK_UNITS));
				end else begin
					last_rd = shreg;
					go_to(PH_NACK_SET, 1'b0, 1'b1, 1'b1, unit_ticks(ACK_UNITS));
				end
			end
			PH_NACK_SET:  go_to(PH_NACK_HIGH, 1'b1, 1'b1, 1'b1, unit_ticks(NACK_UNITS));
			PH_NACK_HIGH: go_to(PH_NACK_LOW, 1'b0, 1'b1, 1'b1, unit_ticks(NACK_UNITS));
			PH_NACK_LOW:  stop_seq();
			PH_STOP_LO:   go_to(PH_STOP_HI, 1'b1, 1'b1, 1'b1, unit_ticks(STOP_UNITS));
			PH_STOP_HI: begin
				if (rd_cmd && byte_idx == 2'd1 && !err) begin
					go_to(PH_REGAP, 1'b1, 1'b1, 1'b1, unit_ticks(GAP_UNITS));
				end else begin
					go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
					done_now = 1'b1;
					fail_now = err;
				end
			end
			PH_REGAP: begin
				byte_idx = 2'd2;
				go_to(PH_START_HI, 1'b1, 1'b1, 1'b1, unit_ticks(START_UNITS));
			end
			default: go_to(PH_IDLE, 1'b1, 1'b1, 1'b1, '0);
		endcase
	endfunction

	// One bus tick: returns the line levels and status after it.
	function automatic res_t sccb_tick(input logic [1:0] k, input logic [7:0] ra,
			input logic [7:0] wd, input logic sda);
		res_t r;
		done_now = 1'b0;
		fail_now = 1'b0;
		if (ph == PH_IDLE) begin
			if (k == KIND_WRITE || k == KIND_READ) begin
				hold_reg = ra;
				hold_data = wd;
				rd_cmd = (k == KIND_READ);
				err = 1'b0;
				byte_idx = 2'd0;
				go_to(PH_START_HI, 1'b1, 1'b1, 1'b1, unit_ticks(START_UNITS));
			end
		end else if (ph == PH_ACK_POLL) begin
			if (!sda) begin
				go_to(PH_ACK_END, 1'b0, 1'b1, 1'b0, unit_ticks(ACK_UNITS));
			end else if (poll_cnt >= poll_lim_q) begin
				err = 1'b1;
				stop_seq();
			end else begin
				poll_cnt++;
			end
		end else if (dly > TIMER_WIDTH'(1)) begin
			dly--;
		end else begin
			dly = '0;
			phase_done(sda);
		end
		r.scl = scl_l;
		r.sda_out = drv_l ? sda_l : 1'b1;
		r.sda_drive = drv_l;
		r.busy = (ph != PH_IDLE);
		r.done = done_now;
		r.failed = fail_now;
		r.read_data = last_rd;
		return r;
	endfunction

	function automatic void cmp_field(input string fname, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			seq_reset();
			line_queue.delete();
			errs = 0;
			seen = 0;
			n_done = 0;
			n_fail = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEV_ADDR: dev_addr_q = cfg_data[ADDR_W-1:0];
					CFG_TICKS:    tpu_q = cfg_data;
					CFG_POLL_LIM: poll_lim_q = cfg_data[POLL_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (line_queue.size() == 0) begin
					$display("%0t: output transfer, expected none, got scl %0b sda_out %0b busy %0b read 0x%0h",
						$time, scl, sda_out, busy_res, read_data);
					errs++;
				end else begin
					want = line_queue.pop_front();
					cmp_field("scl", 8'(want.scl), 8'(scl));
					cmp_field("sda_out", 8'(want.sda_out), 8'(sda_out));
					cmp_field("sda_drive", 8'(want.sda_drive), 8'(sda_drive));
					cmp_field("busy_res", 8'(want.busy), 8'(busy_res));
					cmp_field("done_res", 8'(want.done), 8'(done_res));
					cmp_field("failed", 8'(want.failed), 8'(failed));
					cmp_field("read_data", want.read_data, read_data);
					seen++;
					n_done += want.done;
					n_fail += want.failed;
				end
			end
			if (in_valid && !in_stall) begin
				line_queue.push_back(sccb_tick(kind, reg_addr, write_data, sda_in));
			end
		end
		err_count <= errs;
		pending <= line_queue.size();
		bus_idle <= (ph == PH_IDLE);
		ticks_checked <= seen;
		txn_done <= n_done;
		txn_failed <= n_fail;
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

// Top of the SCCB master testbench. This module only produces stimulus and
// gives the verdict; all prediction and comparison happens in the checker
// instantiated next to the block.
module tb;
	import srm_pkg::*;

	// Kind three has no meaning and must behave like a plain tick.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// Generous bound on the whole run, far above the slowest correct run.
	localparam int CYCLE_LIMIT = 1000000;

	// Cycles to let pass after the last result before touching configuration.
	localparam int SETTLE_CYCLES = 8;

	// Ticks sent at the reset timing before it is sped up.
	localparam int RESET_TIMING_TICKS = 20;

	// Input transfers per random phase.
	localparam int RANDOM_ITEMS = 75;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           kind = KIND_TICK;
	logic [ADDR_W-1:0]    reg_addr = '0;
	logic [DATA_W-1:0]    write_data = '0;
	logic                 sda_in = 1'b1;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 scl, sda_out, sda_drive, busy_res, done_res, failed;
	logic [DATA_W-1:0]    read_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DEV_ADDR;
	logic [TICKS_W-1:0]   cfg_data = '0;

	int   err_count, pending, ticks_checked, txn_done, txn_failed;
	logic bus_idle;

	// Percentages of cycles in which the sender holds back a transfer and in
	// which the receiver stalls. The phases of the run change them.
	int idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	sccb_register_master i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.reg_addr  (reg_addr),
		.write_data(write_data),
		.sda_in    (sda_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.scl       (scl),
		.sda_out   (sda_out),
		.sda_drive (sda_drive),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.failed    (failed),
		.read_data (read_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	srm_bus_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.reg_addr     (reg_addr),
		.write_data   (write_data),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.scl          (scl),
		.sda_out      (sda_out),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.failed       (failed),
		.read_data    (read_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.err_count    (err_count),
		.pending      (pending),
		.bus_idle     (bus_idle),
		.ticks_checked(ticks_checked),
		.txn_done     (txn_done),
		.txn_failed   (txn_failed)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// The receiver decides anew at every edge whether to stall the next cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding", cycles, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	// SDA level that the imagined slave presents, high with the given chance.
	function automatic logic sda_level(input int high_pct);
		return ($urandom_range(0, 99) < high_pct);
	endfunction

	// One input transfer. Random idle cycles go in front of it, then the
	// payload is held until the block takes it. Valid is left high on return,
	// so back-to-back transfers never drop it in between.
	task automatic send_item(input logic [1:0] k, input logic [7:0] ra, input logic [7:0] wd,
			input logic s);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		reg_addr <= ra;
		write_data <= wd;
		sda_in <= s;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// Keep ticking until the bus transaction in progress is over, then let
	// every result come back and the pipeline run dry. At least one tick is
	// sent, since the idle flag from the checker is registered.
	task automatic finish_bus(input int high_pct);
		do begin
			send_item(KIND_TICK, 8'($urandom), 8'($urandom), sda_level(high_pct));
		end while (!bus_idle);
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes leave valid high so that a run of writes never lowers
	// and raises it in the same cycle; set_config lowers it at the end.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TICKS_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
	endtask

	task automatic set_config(input logic [ADDR_W-1:0] dev, input logic [TICKS_W-1:0] tpu,
			input logic [POLL_W-1:0] lim);
		cfg_write(CFG_DEV_ADDR, TICKS_W'(dev));
		cfg_write(CFG_TICKS, tpu);
		cfg_write(CFG_POLL_LIM, TICKS_W'(lim));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random ticks with an occasional command. The slave's SDA behavior
	// drifts between always acknowledging, noisy, mostly high and stuck high,
	// so most transactions complete and some abort on a missing acknowledge.
	// If hold_at is reached, the sender waits there until every result is in.
	task automatic run_random(input int n_items, input int hold_at);
		int         n;
		int         pick;
		int         high_pct;
		logic [1:0] k;
		high_pct = 50;
		for (n = 0; n < n_items; n++) begin
			if ($urandom_range(0, 149) == 0) begin
				case ($urandom_range(0, 4))
					0: high_pct = 0;
					1: high_pct = 25;
					2: high_pct = 50;
					3: high_pct = 94;
					default: high_pct = 100;
				endcase
			end
			if (n == hold_at) begin
				in_valid <= 1'b0;
				do begin
					@(posedge clk);
				end while (pending != 0);
			end
			pick = $urandom_range(0, 31);
			if (pick < 2) begin
				k = KIND_WRITE;
			end else if (pick < 4) begin
				k = KIND_READ;
			end else if (pick == 4) begin
				k = KIND_SPARE;
			end else begin
				k = KIND_TICK;
			end
			send_item(k, 8'($urandom), 8'($urandom), sda_level(high_pct));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset configuration first: a spare kind and a plain
		// tick on the idle bus, then a register write that the slave
		// acknowledges at once. After a few ticks at the reset timing the
		// timing drops to one tick per delay; the start delay already loaded
		// still runs its full length.
		send_item(KIND_SPARE, 8'hFF, 8'hFF, 1'b1);
		send_item(KIND_TICK, 8'h00, 8'h00, 1'b0);
		send_item(KIND_WRITE, 8'h00, 8'hFF, 1'b0);
		repeat (RESET_TIMING_TICKS) send_item(KIND_TICK, 8'h00, 8'h00, 1'b0);
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		set_config(DEV_ADDR_RST, 16'd0, POLL_LIM_RST);
		finish_bus(0);

		// Every delay down to one tick and the widest poll limit. A read with
		// SDA mostly high brings back mostly ones, a read with SDA low zeros.
		set_config(8'hFF, 16'd0, 10'd1023);
		send_item(KIND_READ, 8'hFF, 8'h00, 1'b1);
		finish_bus(94);
		send_item(KIND_READ, 8'h00, 8'hFF, 1'b0);
		finish_bus(0);

		// A poll limit of zero: the first high sample aborts. The failed read
		// must leave the last read byte as it was.
		set_config(8'h00, 16'd0, 10'd0);
		send_item(KIND_WRITE, 8'h55, 8'hAA, 1'b1);
		finish_bus(100);
		send_item(KIND_READ, 8'h0F, 8'hF0, 1'b1);
		finish_bus(100);

		// Commands while a transaction runs must be ignored.
		send_item(KIND_WRITE, 8'h3C, 8'hC3, 1'b0);
		send_item(KIND_READ, 8'hC3, 8'h3C, 1'b0);
		send_item(KIND_WRITE, 8'h81, 8'h7E, 1'b0);
		send_item(KIND_SPARE, 8'h7E, 8'h81, 1'b0);
		finish_bus(0);

		// Slowest timing setting, exercised with ticks only since a single
		// transaction would outlast the cycle limit of the run.
		set_config(8'hA5, 16'hFFFF, 10'd1023);
		send_item(KIND_TICK, 8'hFF, 8'hFF, 1'b1);
		send_item(KIND_SPARE, 8'h00, 8'h00, 1'b0);
		send_item(KIND_TICK, 8'h00, 8'hFF, 1'b1);
		finish_bus(0);

		// Timing and poll limit of one with a noisy slave.
		set_config(8'h5A, 16'd1, 10'd1);
		send_item(KIND_WRITE, 8'hA5, 8'h5A, 1'b0);
		finish_bus(50);

		// Random part, one idling pattern per phase. The first phase runs
		// with no gaps at all.
		set_config(8'($urandom), 16'd0, 10'($urandom_range(1, 4)));
		run_random(RANDOM_ITEMS, -1);
		finish_bus(25);

		// The sender idles about half the time and once waits for the
		// pipeline to empty completely.
		idle_pct = 52;
		set_config(8'($urandom), 16'd0, 10'($urandom_range(1, 1023)));
		run_random(RANDOM_ITEMS, RANDOM_ITEMS / 2);
		finish_bus(25);

		// The receiver stalls about half the time.
		idle_pct = 0;
		stall_pct = 52;
		set_config(8'($urandom), 16'd0, 10'd1);
		run_random(RANDOM_ITEMS, -1);
		finish_bus(25);

		// Both sides hold back, with small and zero poll limits.
		idle_pct = 30;
		stall_pct = 30;
		set_config(8'($urandom), 16'($urandom_range(0, 1)), 10'($urandom_range(0, 8)));
		run_random(RANDOM_ITEMS, -1);
		finish_bus(25);

		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d bus ticks over %0d finished transactions, %0d of them aborted",
			ticks_checked, txn_done, txn_failed);
		$display("on a missing acknowledge; %0d mismatches found", err_count);
		if (err_count == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
